@@ src/ebl_pkg.sv @@
// ---------------------------------------------------------------------------
// ebl_pkg: shared types and constants of the escape-byte lz decompressor
// Beat formats of both channels, the command that crosses the internal
// queue, result kinds and fixed stream-format constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ebl_pkg;

   // request function codes
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_IDLE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // stream format
   localparam logic [31:0] HEADER_BYTES     = 32'd9;
   localparam logic [3:0]  HEADER_LAST      = 4'd8;
   localparam logic [3:0]  SIZE_FIRST       = 4'd4;
   localparam logic [13:0] MIN_MATCH        = 14'd4;
   localparam logic [7:0]  EXTRA_LEN_FLAG   = 8'h04;
   localparam logic [7:0]  OFFSET_SIZE_MASK = 8'h03;

   // input beat
   typedef struct packed {
      logic       func;
      logic [7:0] data_in;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
      logic       copy_pending;
      logic       stream_done;
   } rsp_type;

   // classified command held in the queue
   typedef struct packed {
      logic       drain;
      logic [7:0] data;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

`default_nettype wire

@@ src/ebl_front.sv @@
// ---------------------------------------------------------------------------
// ebl_front: request intake and command queue
// Takes request beats, classifies them as push or drain and holds them in
// a two-entry queue that the back end pops.
// ---------------------------------------------------------------------------
`default_nettype none

module ebl_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire ebl_pkg::req_type req_data,
   output logic                  req_stall,
   input  wire logic             pop,
   output ebl_pkg::head_type     head
);

   ebl_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   ebl_pkg::cmd_type cmd_new;

   // full queue holds off the sender
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   // classify the incoming beat
   always_comb begin
      cmd_new.drain = (req_data.func == ebl_pkg::FUNC_DRAIN);
      cmd_new.data  = req_data.data_in;
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ src/ebl_back.sv @@
// ---------------------------------------------------------------------------
// ebl_back: stream decoder, history memory and result register
// Parses the header and the escape tokens of each pushed byte, keeps the
// history window and plays back copies on drain commands.
// ---------------------------------------------------------------------------
`default_nettype none

module ebl_back #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int DRAIN_BURST   = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ebl_pkg::head_type head,
   output logic                   pop,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output ebl_pkg::rsp_type       rsp_data
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int DW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = DW + 1;
   localparam int CW = (DW > 25) ? DW : 25;
   localparam int BW = (DRAIN_BURST > 1) ? $clog2(DRAIN_BURST) : 1;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LIT    = 5'b00010,
      PH_CODE   = 5'b00100,
      PH_LENX   = 5'b01000,
      PH_OFFS   = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      ENG_RUN   = 3'b001,
      ENG_READ  = 3'b010,
      ENG_WRITE = 3'b100
   } eng_type;

   phase_type   phase_ff, phase_in;
   eng_type     eng_ff, eng_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] payload_ff, payload_in;
   logic [7:0]  esc_ff, esc_in;
   logic [7:0]  code_ff, code_in;
   logic [13:0] len_ff, len_in;
   logic [23:0] off_ff, off_in;
   logic [1:0]  off_left_ff, off_left_in;
   logic [13:0] copy_left_ff, copy_left_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [DW-1:0] written_ff, written_in;
   logic [BW-1:0] burst_ff, burst_in;

   logic [7:0]  hist_mem_ff [HISTORY_DEPTH];
   logic [7:0]  rd_byte_ff;
   logic        rsp_valid_ff;
   ebl_pkg::rsp_type rsp_ff, rsp_in;

   logic        out_free;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic        put_en;
   logic [7:0]  put_byte;
   logic [7:0]  b;
   logic [7:0]  code_v;
   logic [31:0] pay_dec;
   logic        trunc_chk;
   logic [1:0]  off_idx;
   logic [23:0] off_new;
   logic [CW-1:0] dist_v;
   logic        burst_end;
   logic [SW-1:0] rd_diff;
   logic [SW-1:0] rd_wrap;
   logic [AW-1:0] rd_addr;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b        = head.cmd.data;

   // copy source: write pointer minus distance, wrapped into the window
   always_comb begin
      rd_diff = SW'(wp_ff) - SW'(dist_ff);
      rd_wrap = rd_diff + SW'(HISTORY_DEPTH);
      rd_addr = rd_diff[SW-1] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
   end

   // decode and copy sequencing
   always_comb begin
      phase_in     = phase_ff;
      eng_in       = eng_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      payload_in   = payload_ff;
      esc_in       = esc_ff;
      code_in      = code_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      off_left_in  = off_left_ff;
      copy_left_in = copy_left_ff;
      dist_in      = dist_ff;
      burst_in     = burst_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      emit_kind    = ebl_pkg::KIND_BYTE;
      emit_byte    = 8'd0;
      emit_last    = 1'b1;
      put_en       = 1'b0;
      put_byte     = 8'd0;
      code_v       = (b > esc_ff) ? (b - 8'd1) : b;
      pay_dec      = payload_ff - 32'd1;
      trunc_chk    = 1'b0;
      off_idx      = code_ff[1:0] + 2'd1 - off_left_ff;
      off_new      = off_ff | (24'(b) << {off_idx, 3'b000});
      dist_v       = CW'(off_new) + CW'(1);
      burst_end    = (burst_ff == BW'(DRAIN_BURST - 1));

      unique case (eng_ff)
         ENG_RUN: begin
            if (head.valid && out_free) begin
               if (head.cmd.drain) begin
                  if (copy_left_ff == 14'd0) begin
                     emit      = 1'b1;
                     emit_kind = ebl_pkg::KIND_IDLE;
                     pop       = 1'b1;
                  end else begin
                     eng_in   = ENG_READ;
                     burst_in = '0;
                  end
               end else begin
                  pop = 1'b1;
                  if (phase_ff == PH_HEADER) begin
                     // header: size bytes then the escape value
                     if (hdr_cnt_ff >= ebl_pkg::SIZE_FIRST && hdr_cnt_ff < ebl_pkg::HEADER_LAST) begin
                        payload_in = payload_ff | (32'(b) << {hdr_cnt_ff[1:0], 3'b000});
                     end
                     if (hdr_cnt_ff >= ebl_pkg::HEADER_LAST) begin
                        esc_in     = b;
                        payload_in = (payload_ff >= ebl_pkg::HEADER_BYTES) ?
                                     (payload_ff - ebl_pkg::HEADER_BYTES) : 32'd0;
                        phase_in   = PH_LIT;
                        hdr_cnt_in = 4'd0;
                     end else begin
                        hdr_cnt_in = hdr_cnt_ff + 4'd1;
                     end
                  end else if (copy_left_ff != 14'd0 || payload_ff == 32'd0) begin
                     // byte while a copy waits or after the end
                     emit      = 1'b1;
                     emit_kind = ebl_pkg::KIND_ERROR;
                  end else begin
                     payload_in = pay_dec;
                     unique case (phase_ff)
                        PH_CODE: begin
                           if (b == esc_ff) begin
                              phase_in  = PH_LIT;
                              put_en    = 1'b1;
                              put_byte  = b;
                              emit      = 1'b1;
                              emit_byte = b;
                           end else begin
                              code_in = code_v;
                              if ((code_v & ebl_pkg::OFFSET_SIZE_MASK) ==
                                  ebl_pkg::OFFSET_SIZE_MASK) begin
                                 phase_in  = PH_LIT;
                                 emit      = 1'b1;
                                 emit_kind = ebl_pkg::KIND_ERROR;
                              end else begin
                                 len_in      = 14'(code_v >> 3);
                                 off_in      = 24'd0;
                                 off_left_in = code_v[1:0] + 2'd1;
                                 phase_in    = ((code_v & ebl_pkg::EXTRA_LEN_FLAG) != 8'd0) ?
                                               PH_LENX : PH_OFFS;
                                 trunc_chk   = 1'b1;
                              end
                           end
                        end
                        PH_LENX: begin
                           len_in    = len_ff | (14'(b) << 5);
                           phase_in  = PH_OFFS;
                           trunc_chk = 1'b1;
                        end
                        PH_OFFS: begin
                           off_in      = off_new;
                           off_left_in = off_left_ff - 2'd1;
                           if (off_left_ff == 2'd1) begin
                              // offset complete: check reach and arm the copy
                              phase_in = PH_LIT;
                              if (dist_v > CW'(written_ff)) begin
                                 emit      = 1'b1;
                                 emit_kind = ebl_pkg::KIND_ERROR;
                              end else begin
                                 dist_in      = DW'(dist_v);
                                 copy_left_in = len_ff + ebl_pkg::MIN_MATCH;
                              end
                           end else begin
                              trunc_chk = 1'b1;
                           end
                        end
                        default: begin
                           if (b != esc_ff) begin
                              put_en    = 1'b1;
                              put_byte  = b;
                              emit      = 1'b1;
                              emit_byte = b;
                           end else begin
                              phase_in  = PH_CODE;
                              trunc_chk = 1'b1;
                           end
                        end
                     endcase
                     // payload ended inside a token
                     if (trunc_chk && pay_dec == 32'd0) begin
                        phase_in  = PH_LIT;
                        emit      = 1'b1;
                        emit_kind = ebl_pkg::KIND_ERROR;
                     end
                  end
               end
            end
         end
         ENG_READ: begin
            eng_in = ENG_WRITE;
         end
         ENG_WRITE: begin
            // copied byte goes back into the window and out
            if (out_free) begin
               put_en       = 1'b1;
               put_byte     = rd_byte_ff;
               copy_left_in = copy_left_ff - 14'd1;
               emit         = 1'b1;
               emit_byte    = rd_byte_ff;
               emit_last    = (copy_left_in == 14'd0) || burst_end;
               if (emit_last) begin
                  pop    = 1'b1;
                  eng_in = ENG_RUN;
               end else begin
                  eng_in   = ENG_READ;
                  burst_in = burst_ff + BW'(1);
               end
            end
         end
         default: begin
            eng_in = ENG_RUN;
         end
      endcase

      // history pointer and fill level
      wp_in      = wp_ff;
      written_in = written_ff;
      if (put_en) begin
         wp_in      = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : (wp_ff + AW'(1));
         written_in = (written_ff == DW'(HISTORY_DEPTH)) ? written_ff :
                      (written_ff + DW'(1));
      end

      // result as seen after this step
      rsp_in.out_byte     = emit_byte;
      rsp_in.kind         = emit_kind;
      rsp_in.last_of_run  = emit_last;
      rsp_in.copy_pending = (copy_left_in != 14'd0);
      rsp_in.stream_done  = (phase_in != PH_HEADER) && (payload_in == 32'd0) &&
                            (copy_left_in == 14'd0);
   end

   // control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         eng_ff       <= ENG_RUN;
         hdr_cnt_ff   <= 4'd0;
         payload_ff   <= 32'd0;
         esc_ff       <= 8'd0;
         code_ff      <= 8'd0;
         len_ff       <= 14'd0;
         off_ff       <= 24'd0;
         off_left_ff  <= 2'd0;
         copy_left_ff <= 14'd0;
         dist_ff      <= '0;
         wp_ff        <= '0;
         written_ff   <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         eng_ff       <= eng_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         payload_ff   <= payload_in;
         esc_ff       <= esc_in;
         code_ff      <= code_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
         off_left_ff  <= off_left_in;
         copy_left_ff <= copy_left_in;
         dist_ff      <= dist_in;
         wp_ff        <= wp_in;
         written_ff   <= written_in;
         burst_ff     <= burst_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // history window: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (put_en) begin
         hist_mem_ff[wp_ff] <= put_byte;
      end
      if (eng_ff == ENG_READ) begin
         rd_byte_ff <= hist_mem_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ src/escape_byte_lz_decompressor.sv @@
// ---------------------------------------------------------------------------
// escape_byte_lz_decompressor: escape-byte lz77 stream decoder
// Header parse, literal and back-reference decode with a history window;
// copies play out through drain requests in bursts.
// ---------------------------------------------------------------------------
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  ebl_pkg::req_type (func, data_in)
//   rsp_     out        rsp_valid/rsp_stall  ebl_pkg::rsp_type (byte, kind, flags)
//
// push beats: written into the queue, then decoded at the queue head once
// the result register is free; the result is registered
// drain beats: each copied byte is a history read, then write-back and result,
// up to DRAIN_BURST bytes per drain
// reset is synchronous; the history memory is not cleared
// the two-entry queue keeps taking beats, until it is full, while rsp_stall holds the decoder
// ---------------------------------------------------------------------------
`default_nettype none

module escape_byte_lz_decompressor #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int DRAIN_BURST   = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ebl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ebl_pkg::rsp_type      rsp_data
);

   ebl_pkg::head_type head;
   logic              pop;

   // intake and queue
   ebl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .pop       (pop),
      .head      (head)
   );

   // decoder and history
   ebl_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .DRAIN_BURST   (DRAIN_BURST)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/ebl_checker.sv @@
// ---------------------------------------------------------------------------
// ebl_checker: port-level checks of the decompressor
// Watches the result channel over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module ebl_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ebl_pkg::rsp_type rsp_data
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // only decoded bytes carry a value
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ebl_pkg::KIND_BYTE |-> rsp_data.out_byte == 8'd0)
      else $error("non-byte result carries a value");

   // errors and idle drains are single results
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ebl_pkg::KIND_BYTE |-> rsp_data.last_of_run)
      else $error("non-byte result not last of run");

   // a pending copy means the stream is not done
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.copy_pending |-> !rsp_data.stream_done)
      else $error("stream done while copy pending");

endmodule

bind escape_byte_lz_decompressor ebl_checker u_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench of the escape-byte lz decompressor
// Feeds one compressed stream (header, literals, escaped escapes, copies,
// bad codes, far distances, a cut-off token and bytes past the end) with
// drains between, and checks every result beat against the decoder model kept
// in the testbench or the plan. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HISTORY_DEPTH = 65536;
   localparam int DRAIN_BURST   = 64;
   localparam int PAYLOAD_LEN   = 120;
   localparam logic [31:0] TOTAL_SIZE = ebl_pkg::HEADER_BYTES + PAYLOAD_LEN;

   typedef enum logic [2:0] {
      DEC_HEADER,
      DEC_LITERAL,
      DEC_CODE,
      DEC_LENGTH,
      DEC_OFFSET
   } dec_phase_type;

   // one row of the directed part; result is used only when typed is set
   typedef struct packed {
      ebl_pkg::req_type beat;
      logic             typed;
      ebl_pkg::rsp_type result;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ebl_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ebl_pkg::rsp_type rsp_data;

   // decoder model state
   dec_phase_type dec_phase        = DEC_HEADER;
   logic [3:0]    hdr_count        = '0;
   logic [31:0]   bytes_left       = '0;
   logic [7:0]    esc_value        = '0;
   logic [7:0]    held_code        = '0;
   logic [13:0]   run_length       = '0;
   logic [24:0]   offset_value     = '0;
   logic [1:0]    offset_bytes_due = '0;
   logic [13:0]   copy_remaining   = '0;
   logic [24:0]   copy_dist        = '0;
   int            wr_ptr           = 0;
   int            wr_count         = 0;
   logic [7:0]    window [HISTORY_DEPTH];

   ebl_pkg::rsp_type results_due [$];
   ebl_pkg::rsp_type fresh_results [$];

   bit quiet_mode   = 1'b0;
   int stall_due    = 0;
   int beats_sent   = 0;
   int drains_sent  = 0;
   int results_seen = 0;
   int fail_count   = 0;

   escape_byte_lz_decompressor #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .DRAIN_BURST  (DRAIN_BURST)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // decoder model
   // ---------------------------------------------------------------------

   // queue one result beat of the current input beat
   task automatic post(input logic [7:0] value, input logic [1:0] kind, input logic last);
      ebl_pkg::rsp_type r;
      r.out_byte     = (kind == ebl_pkg::KIND_BYTE) ? value : 8'h00;
      r.kind         = kind;
      r.last_of_run  = last;
      r.copy_pending = (copy_remaining != 0);
      r.stream_done  = (dec_phase != DEC_HEADER) && (bytes_left == 0) &&
                       (copy_remaining == 0);
      fresh_results.push_back(r);
   endtask

   // append a decoded byte to the window
   task automatic store(input logic [7:0] value);
      window[wr_ptr] = value;
      wr_ptr = (wr_ptr == HISTORY_DEPTH - 1) ? 0 : wr_ptr + 1;
      if (wr_count < HISTORY_DEPTH) wr_count++;
   endtask

   // advance the model by one accepted beat, results go to fresh_results
   task automatic decode_beat(input ebl_pkg::req_type beat);
      int          rd_index;
      int          pos;
      int          n;
      logic [7:0]  b;
      logic [7:0]  value;
      logic [24:0] distance;
      logic        token_open;
      b = beat.data_in;
      token_open = 1'b0;
      if (beat.func == ebl_pkg::FUNC_DRAIN) begin
         if (copy_remaining == 0) begin
            post(8'h00, ebl_pkg::KIND_IDLE, 1'b1);
         end else begin
            // byte by byte, so an overlapping copy repeats with its distance
            for (n = 0; n < DRAIN_BURST && copy_remaining != 0; n++) begin
               rd_index = (wr_ptr + HISTORY_DEPTH - int'(copy_dist)) % HISTORY_DEPTH;
               value = window[rd_index];
               store(value);
               copy_remaining--;
               post(value, ebl_pkg::KIND_BYTE,
                    (copy_remaining == 0) || (n == DRAIN_BURST - 1));
            end
         end
      end else if (dec_phase == DEC_HEADER) begin
         if (hdr_count >= ebl_pkg::SIZE_FIRST && hdr_count < ebl_pkg::HEADER_LAST)
            bytes_left = bytes_left |
                         (32'(b) << (8 * (hdr_count - ebl_pkg::SIZE_FIRST)));
         if (hdr_count == ebl_pkg::HEADER_LAST) begin
            esc_value  = b;
            bytes_left = (bytes_left >= ebl_pkg::HEADER_BYTES) ?
                         bytes_left - ebl_pkg::HEADER_BYTES : 32'd0;
            dec_phase  = DEC_LITERAL;
            hdr_count  = '0;
         end else begin
            hdr_count++;
         end
      end else if (copy_remaining != 0 || bytes_left == 0) begin
         // copy still waiting or stream over: byte is dropped
         post(8'h00, ebl_pkg::KIND_ERROR, 1'b1);
      end else begin
         bytes_left--;
         token_open = 1'b1;
         case (dec_phase)
            DEC_CODE: begin
               if (b == esc_value) begin
                  dec_phase = DEC_LITERAL;
                  store(b);
                  post(b, ebl_pkg::KIND_BYTE, 1'b1);
                  token_open = 1'b0;
               end else begin
                  held_code = (b > esc_value) ? b - 8'd1 : b;
                  if ((held_code & ebl_pkg::OFFSET_SIZE_MASK) ==
                      ebl_pkg::OFFSET_SIZE_MASK) begin
                     dec_phase = DEC_LITERAL;
                     post(8'h00, ebl_pkg::KIND_ERROR, 1'b1);
                     token_open = 1'b0;
                  end else begin
                     run_length       = 14'(held_code[7:3]);
                     offset_value     = '0;
                     offset_bytes_due = held_code[1:0] + 2'd1;
                     dec_phase = ((held_code & ebl_pkg::EXTRA_LEN_FLAG) != 0) ?
                                 DEC_LENGTH : DEC_OFFSET;
                  end
               end
            end
            DEC_LENGTH: begin
               run_length = run_length | {1'b0, b, 5'b00000};
               dec_phase  = DEC_OFFSET;
            end
            DEC_OFFSET: begin
               // offset bytes arrive low byte first
               pos = int'(held_code[1:0]) + 1 - int'(offset_bytes_due);
               offset_value = offset_value | (25'(b) << (8 * pos));
               offset_bytes_due--;
               if (offset_bytes_due == 0) begin
                  distance   = offset_value + 25'd1;
                  dec_phase  = DEC_LITERAL;
                  token_open = 1'b0;
                  if (distance > HISTORY_DEPTH || distance > wr_count) begin
                     post(8'h00, ebl_pkg::KIND_ERROR, 1'b1);
                  end else begin
                     copy_dist      = distance;
                     copy_remaining = run_length + ebl_pkg::MIN_MATCH;
                  end
               end
            end
            default: begin
               if (b != esc_value) begin
                  store(b);
                  post(b, ebl_pkg::KIND_BYTE, 1'b1);
                  token_open = 1'b0;
               end else begin
                  dec_phase = DEC_CODE;
               end
            end
         endcase
         // payload ran out inside a token
         if (token_open && bytes_left == 0) begin
            dec_phase = DEC_LITERAL;
            post(8'h00, ebl_pkg::KIND_ERROR, 1'b1);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // drive one beat, wait for it to be taken, then predict its results
   task automatic send_beat(input ebl_pkg::req_type beat, input logic typed,
                            input ebl_pkg::rsp_type known);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fresh_results.delete();
      decode_beat(beat);
      if (typed) begin
         results_due.push_back(known);
      end else begin
         foreach (fresh_results[i]) results_due.push_back(fresh_results[i]);
      end
      beats_sent++;
      if (beat.func == ebl_pkg::FUNC_DRAIN) drains_sent++;
   endtask

   task automatic send_push(input logic [7:0] data);
      ebl_pkg::req_type beat;
      beat.func    = ebl_pkg::FUNC_PUSH;
      beat.data_in = data;
      send_beat(beat, 1'b0, '0);
   endtask

   task automatic send_drain();
      ebl_pkg::req_type beat;
      beat.func    = ebl_pkg::FUNC_DRAIN;
      beat.data_in = 8'($urandom_range(0, 255));
      send_beat(beat, 1'b0, '0);
   endtask

   // hold off the sender until every predicted result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   // code byte as it travels: values at or above the escape move up by one
   function automatic logic [7:0] encode_code(input logic [7:0] code);
      return (code >= esc_value) ? code + 8'd1 : code;
   endfunction

   function automatic logic [7:0] literal_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      return (v == esc_value) ? ~v : v;
   endfunction

   function automatic plan_row_type plain_row(input logic func, input logic [7:0] data);
      plan_row_type row;
      row = '0;
      row.beat.func    = func;
      row.beat.data_in = data;
      return row;
   endfunction

   function automatic plan_row_type known_row(input logic func, input logic [7:0] data,
                                              input logic [7:0] value,
                                              input logic [1:0] kind,
                                              input logic pending, input logic done);
      plan_row_type row;
      row = plain_row(func, data);
      row.typed               = 1'b1;
      row.result.out_byte     = value;
      row.result.kind         = kind;
      row.result.last_of_run  = 1'b1;
      row.result.copy_pending = pending;
      row.result.stream_done  = done;
      return row;
   endfunction

   initial begin : stimulus
      plan_row_type plan [$];
      logic [4:0]   len_bits;
      logic         has_extra;
      logic [1:0]   size;
      logic [7:0]   code;
      logic [23:0]  offset;
      int           span;
      int           pick;
      int           needed;
      bit           far;

      // header: decoded size (not used), total size, escape 0x80
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'hFF));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h00));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h5A));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'hA5));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, TOTAL_SIZE[7:0]));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, TOTAL_SIZE[15:8]));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, TOTAL_SIZE[23:16]));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, TOTAL_SIZE[31:24]));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h80));
      // literal extremes and an escaped escape
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'h00, 8'h00, ebl_pkg::KIND_BYTE,
                               1'b0, 1'b0));
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'hFF, 8'hFF, ebl_pkg::KIND_BYTE,
                               1'b0, 1'b0));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h80));
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'h80, 8'h80, ebl_pkg::KIND_BYTE,
                               1'b0, 1'b0));
      // code above the escape: length 31 plus extra byte, distance 3, 67 bytes
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h80));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'hFD));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h01));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h02));
      // push while the copy waits, then a full burst, the tail, nothing left
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'h55, 8'h00, ebl_pkg::KIND_ERROR,
                               1'b1, 1'b0));
      plan.push_back(plain_row(ebl_pkg::FUNC_DRAIN, 8'h00));
      plan.push_back(plain_row(ebl_pkg::FUNC_DRAIN, 8'hFF));
      plan.push_back(known_row(ebl_pkg::FUNC_DRAIN, 8'h00, 8'h00, ebl_pkg::KIND_IDLE,
                               1'b0, 1'b0));
      // offset size three
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h80));
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'h03, 8'h00, ebl_pkg::KIND_ERROR,
                               1'b0, 1'b0));
      // distance 256 beyond the bytes written so far
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h80));
      plan.push_back(plain_row(ebl_pkg::FUNC_PUSH, 8'h00));
      plan.push_back(known_row(ebl_pkg::FUNC_PUSH, 8'hFF, 8'h00, ebl_pkg::KIND_ERROR,
                               1'b0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].result);
      wait_for_results();

      // random tokens until the payload is used up and no copy waits
      while (bytes_left != 0 || copy_remaining != 0) begin
         quiet_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 24) == 0) wait_for_results();
         pick     = $urandom_range(0, 99);
         len_bits = 5'($urandom_range(0, 31));
         if (copy_remaining != 0) begin
            if (pick < 10) send_push(8'($urandom_range(0, 255)));
            else send_drain();
         end else if (bytes_left == 2) begin
            // token cut off by the end of the payload
            send_push(esc_value);
            send_push(encode_code({len_bits, 3'b000}));
         end else if (bytes_left == 1 || pick < 40) begin
            send_push(literal_byte());
         end else if (pick < 50) begin
            send_push(esc_value);
            send_push(esc_value);
         end else if (pick < 55) begin
            code = {len_bits, 1'($urandom_range(0, 1)), 2'b11};
            if (code == 8'hFF) code[2] = 1'b0;
            send_push(esc_value);
            send_push(encode_code(code));
         end else if (pick < 60) begin
            send_drain();
         end else begin
            has_extra = ($urandom_range(0, 5) == 0);
            far       = ($urandom_range(0, 9) == 0);
            if (far) begin
               size   = 2'd2;
               offset = 24'($urandom_range(24'hFFFFFF, wr_count));
            end else begin
               span   = (wr_count < 300) ? wr_count : 300;
               offset = 24'($urandom_range(1, span) - 1);
               size   = (offset > 255) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 2));
            end
            needed = 3 + int'(has_extra) + int'(size);
            if (bytes_left < needed) begin
               send_push(literal_byte());
            end else begin
               code = {len_bits, 3'b000} |
                      (has_extra ? ebl_pkg::EXTRA_LEN_FLAG : 8'h00) | 8'(size);
               send_push(esc_value);
               send_push(encode_code(code));
               if (has_extra) send_push(8'($urandom_range(0, 3)));
               for (int k = 0; k <= int'(size); k++) send_push(offset[8 * k +: 8]);
            end
         end
      end

      // beats after the end of the stream
      quiet_mode = 1'b0;
      send_push(8'($urandom_range(0, 255)));
      send_drain();
      send_push(literal_byte());
      send_drain();
      req_valid <= 1'b0;

      while (results_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("one stream of %0d payload bytes: %0d beats sent, %0d of them drains",
               PAYLOAD_LEN, beats_sent, drains_sent);
      $display("%0d result beats checked against the decoder model", results_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // result side: random stall after each beat, compare with oldest expected
   // ---------------------------------------------------------------------
   task automatic check_beat(input ebl_pkg::rsp_type got);
      ebl_pkg::rsp_type want;
      results_seen++;
      if (results_due.size() == 0) begin
         $error("result beat with nothing expected: out_byte %02h kind %0d",
                got.out_byte, got.kind);
         fail_count++;
      end else begin
         want = results_due.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            fail_count++;
         end
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            fail_count++;
         end
         if (got.copy_pending !== want.copy_pending) begin
            $error("copy_pending: expected %0b, got %0b", want.copy_pending, got.copy_pending);
            fail_count++;
         end
         if (got.stream_done !== want.stream_done) begin
            $error("stream_done: expected %0b, got %0b", want.stream_done, got.stream_done);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_due = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_beat(rsp_data);
            stall_due = quiet_mode ? 0 : $urandom_range(0, 4);
         end
         rsp_stall <= (stall_due != 0);
         if (stall_due != 0) stall_due--;
      end
   end

   // overall time limit
   initial begin : watchdog
      #5_000_000;
      $error("timed out with %0d result beats outstanding", results_due.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
